// ===== sv/rgba_pixel_filter_3x3_unit_macros.svh =====
// Assertion macros for the checker file of the pixel filter.
// Included by name; holds only macro definitions.
`ifndef RGBA_PIXEL_FILTER_3X3_UNIT_MACROS_SVH
`define RGBA_PIXEL_FILTER_3X3_UNIT_MACROS_SVH

// Condition must hold at every edge while reset is released.
`define RPF3_ASSERT_NOW(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("pixel filter check failed");

// Antecedent at one edge implies consequent at the next edge.
`define RPF3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pixel filter check failed");

`endif

// ===== sv/rpf3_pkg.sv =====
// Package of the 3x3 pixel filter: modes, register indexes, kernels, queue entry type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rpf3_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int QDepth      = 4;

  localparam logic [2:0] ModePass    = 3'd0;
  localparam logic [2:0] ModeGray    = 3'd1;
  localparam logic [2:0] ModeInvert  = 3'd2;
  localparam logic [2:0] ModeBinary  = 3'd3;
  localparam logic [2:0] ModeWarm    = 3'd4;
  localparam logic [2:0] ModeCool    = 3'd5;
  localparam logic [2:0] ModeEdge    = 3'd6;
  localparam logic [2:0] ModeSharpen = 3'd7;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  localparam logic [10:0] WidthRst  = 11'd1024;
  localparam logic [12:0] HeightRst = 13'd768;

  localparam logic signed [4:0] KEdge [9] = '{
    5'sd0, -5'sd1, 5'sd0, -5'sd1, 5'sd5, -5'sd1, 5'sd0, -5'sd1, 5'sd0};
  localparam logic signed [4:0] KSharp [9] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1};

  // Border flags of the centre pixel plus the end-of-frame marker.
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } pos_flags_t;

  typedef struct packed {
    logic [8:0][31:0] win;
    pos_flags_t       flags;
  } q_entry_t;

  // Exact floor(v / 20) for v below 8192, by reciprocal multiplication.
  function automatic logic [8:0] div20(input logic [12:0] v);
    logic [28:0] p;
    begin
      p = 29'(v) * 29'd3277;
      div20 = p[24:16];
    end
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] v);
    begin
      sat8 = v[8] ? 8'd255 : v[7:0];
    end
  endfunction

endpackage

// ===== sv/rgba_pixel_filter_3x3_unit.sv =====
// Top level of the streaming RGBA 3x3 pixel filter.
// Depends on rpf3_pkg, rpf3_front, rpf3_queue and rpf3_back.
// Usage:
// Pixels enter in raster order on the input channel (in_valid_i / in_stall_o),
// one word per accepted cycle. Filtered pixels leave on the output channel
// (out_valid_o / out_stall_i). The result for source position p is produced
// when the item for position p + width + 1 enters, so after each frame the
// source sends width + 1 flush words (is_flush_i high) to drain the last row;
// frame_end_o marks the last pixel of the frame.
// Throughput is one word per cycle while the queue has space: the front
// accepts a new word while the back still holds results. The word that
// completes a window is registered with its line buffer reads, then shifted
// into the window and queued, then filtered into the output register.
// The line buffers are single memories per row, read and written once per
// accepted word, which sets the one-word-per-cycle limit.
// When the receiver stalls, the output register holds its word, the four-entry
// queue fills, and then in_stall_o rises. Reset clears the window, position,
// queue and output valid; line buffer contents are left as they are.
// Configuration writes (cfg_valid_i, always ready) are made while idle.
`timescale 1ns / 1ps

module rgba_pixel_filter_3x3_unit import rpf3_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  input  logic [7:0]  in_alpha_i,
  input  logic        is_flush_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        frame_end_o
);

  logic       q_space, q_push, q_pop, q_nonempty;
  q_entry_t   q_wdata, q_head;
  logic [2:0] mode;

  // Registers never need to wait.
  assign cfg_ready_o = 1'b1;

  rpf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .in_red_i, .in_green_i, .in_blue_i, .in_alpha_i, .is_flush_i,
    .q_space_i (q_space),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata),
    .mode_o    (mode)
  );

  rpf3_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (q_push),
    .data_i     (q_wdata),
    .pop_i      (q_pop),
    .space_o    (q_space),
    .nonempty_o (q_nonempty),
    .head_o     (q_head)
  );

  rpf3_back u_back (
    .clk_i, .rst_ni,
    .mode_i       (mode),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o, .out_stall_i,
    .out_red_o, .out_green_o, .out_blue_o, .out_alpha_o, .frame_end_o
  );

endmodule

// ===== sv/rpf3_front.sv =====
// Front part of the pixel filter: configuration registers, frame position,
// line buffers and the 3x3 window. Depends on rpf3_pkg.
`timescale 1ns / 1ps

module rpf3_front import rpf3_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [12:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_red_i,
  input  logic [7:0]     in_green_i,
  input  logic [7:0]     in_blue_i,
  input  logic [7:0]     in_alpha_i,
  input  logic           is_flush_i,
  input  logic           q_space_i,
  output logic           q_push_o,
  output q_entry_t       q_data_o,
  output logic [2:0]     mode_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [2:0]  mode_q;
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [XW-1:0] col_q, col_d;
  logic [12:0]   row_q, row_d;

  logic [31:0] prev_mem  [MAX_WIDTH];
  logic [31:0] prev2_mem [MAX_WIDTH];
  logic [31:0] mid_q, top_q;

  logic          a_valid_q;
  logic [XW-1:0] a_x_q;
  logic [31:0]   a_pix_q;
  logic          a_emit_q;
  pos_flags_t    a_flags_q;

  logic [8:0][31:0] win_q, win_d;

  logic [WW-1:0] weff;
  logic [12:0]   heff;
  logic [XW-1:0] x_cur;
  logic [12:0]   y_cur, cy;
  logic [WW-1:0] cx;
  logic          wrap, emit, accept, adv;
  logic [31:0]   pix;
  pos_flags_t    flags;

  assign adv        = a_valid_q && q_space_i;
  assign accept     = in_valid_i && (!a_valid_q || adv);
  assign in_stall_o = a_valid_q && !adv;
  assign mode_o     = mode_q;

  always_comb begin
    if (32'(width_q) > MAX_WIDTH) begin
      weff = WW'(MAX_WIDTH);
    end else if (width_q == 11'd0) begin
      weff = WW'(1);
    end else begin
      weff = WW'(width_q);
    end
    heff  = (height_q == 13'd0) ? 13'd1 : height_q;
    wrap  = WW'(col_q) >= weff;
    x_cur = wrap ? '0 : col_q;
    y_cur = wrap ? '0 : row_q;
    pix   = is_flush_i ? 32'd0 : {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    emit  = (y_cur >= 13'd2) || (y_cur == 13'd1 && x_cur != '0);
    if (x_cur == '0) begin
      cx = weff - WW'(1);
      cy = y_cur - 13'd2;
    end else begin
      cx = WW'(x_cur) - WW'(1);
      cy = y_cur - 13'd1;
    end
    flags.left   = cx == '0;
    flags.right  = cx == weff - WW'(1);
    flags.top    = cy == 13'd0;
    flags.bottom = cy == heff - 13'd1;
    flags.last   = emit && flags.right && flags.bottom;
    if (flags.last) begin
      col_d = '0;
      row_d = '0;
    end else if (WW'(x_cur) + WW'(1) >= weff) begin
      col_d = '0;
      row_d = y_cur + 13'd1;
    end else begin
      col_d = x_cur + XW'(1);
      row_d = y_cur;
    end
  end

  // Configuration and frame position; a size write restarts the position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModePass;
      width_q  <= WidthRst;
      height_q <= HeightRst;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMode: mode_q <= cfg_data_i[2:0];
        RegWidth: begin
          width_q <= cfg_data_i[10:0];
          col_q   <= '0;
          row_q   <= '0;
        end
        RegHeight: begin
          height_q <= cfg_data_i;
          col_q    <= '0;
          row_q    <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_q           <= prev_mem[x_cur];
      prev_mem[x_cur] <= pix;
    end
  end

  // The older row is written on advance; forward it on an address match.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= (adv && a_x_q == x_cur) ? mid_q : prev2_mem[x_cur];
    end
    if (adv) begin
      prev2_mem[a_x_q] <= mid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q     <= x_cur;
      a_pix_q   <= pix;
      a_emit_q  <= emit;
      a_flags_q <= flags;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top_q;
    win_d[5] = mid_q;
    win_d[8] = a_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv) begin
      win_q <= win_d;
    end
  end

  assign q_push_o       = adv && a_emit_q;
  assign q_data_o.win   = win_d;
  assign q_data_o.flags = a_flags_q;

endmodule

// ===== sv/rpf3_queue.sv =====
// Short queue between the front and back parts of the pixel filter.
// Depends on rpf3_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rpf3_queue import rpf3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t data_i,
  input  logic     pop_i,
  output logic     space_o,
  output logic     nonempty_o,
  output q_entry_t head_o
);

  localparam int PW = $clog2(QDepth);

  q_entry_t        mem_q [QDepth];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;

  assign nonempty_o = cnt_q != '0;
  assign space_o    = (cnt_q != (PW+1)'(QDepth)) || pop_i;
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== sv/rpf3_back.sv =====
// Back part of the pixel filter: border selection, point and 3x3 filters,
// output register. Depends on rpf3_pkg.
`timescale 1ns / 1ps

module rpf3_back import rpf3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] mode_i,
  input  logic       q_nonempty_i,
  input  q_entry_t   q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       frame_end_o
);

  logic [8:0][31:0] sel;
  logic [7:0]  cr, cg, cb;
  logic [12:0] gray_sum;
  logic [7:0]  gray;
  logic [7:0]  res [3];
  logic signed [13:0] acc [3];
  int unsigned sr, sc;
  logic        valid_q;

  assign q_pop_o     = q_nonempty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sr = (r == 0) ? (q_head_i.flags.top ? 1 : 0)
           : (r == 1) ? 1 : (q_head_i.flags.bottom ? 1 : 2);
        sc = (c == 0) ? (q_head_i.flags.left ? 1 : 0)
           : (c == 1) ? 1 : (q_head_i.flags.right ? 1 : 2);
        sel[r*3+c] = q_head_i.win[sr*3+sc];
      end
    end
    cr = sel[4][7:0];
    cg = sel[4][15:8];
    cb = sel[4][23:16];
    gray_sum = 13'(cr) * 13'd11 + 13'(cg) * 13'd16 + 13'(cb) * 13'd5;
    gray = gray_sum[12:5];
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int i = 0; i < 9; i++) begin
        acc[ch] = acc[ch] + 14'((mode_i == ModeEdge) ? KEdge[i] : KSharp[i])
                * $signed({6'd0, sel[i][ch*8 +: 8]});
      end
    end
    unique case (mode_i)
      ModeGray: begin
        res[0] = gray; res[1] = gray; res[2] = gray;
      end
      ModeInvert: begin
        res[0] = ~cr; res[1] = ~cg; res[2] = ~cb;
      end
      ModeBinary: begin
        res[0] = (gray > 8'd128) ? 8'd255 : 8'd0;
        res[1] = res[0];
        res[2] = res[0];
      end
      ModeWarm: begin
        res[0] = sat8(div20(13'(cr) * 13'd23));
        res[1] = sat8(div20(13'(cg) * 13'd21));
        res[2] = sat8(div20(13'(cb) * 13'd18));
      end
      ModeCool: begin
        res[0] = sat8(div20(13'(cr) * 13'd18));
        res[1] = cg;
        res[2] = sat8(div20(13'(cb) * 13'd23));
      end
      ModeEdge, ModeSharpen: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (acc[ch] < 0) res[ch] = 8'd0;
          else if (acc[ch] > 14'sd255) res[ch] = 8'd255;
          else res[ch] = acc[ch][7:0];
        end
      end
      default: begin
        res[0] = cr; res[1] = cg; res[2] = cb;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= q_nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_red_o   <= res[0];
      out_green_o <= res[1];
      out_blue_o  <= res[2];
      out_alpha_o <= sel[4][31:24];
      frame_end_o <= q_head_i.flags.last;
    end
  end

endmodule

// ===== sv/rpf3_checker.sv =====
// Port-level checks of the pixel filter, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "rgba_pixel_filter_3x3_unit_macros.svh"

module rpf3_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic       frame_end_o
);

  // A held output word keeps its red channel and frame-end flag.
  `RPF3_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_red_o) && $stable(frame_end_o))
  // Nothing is offered in the cycle reset is released.
  `RPF3_ASSERT_NOW(a_rst_quiet, clk_i, 1'b1, $past(rst_ni) || !out_valid_o)
  // The register port never pushes back.
  `RPF3_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)

endmodule

bind rgba_pixel_filter_3x3_unit rpf3_checker u_rpf3_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .out_valid_o, .out_stall_i, .out_red_o, .frame_end_o
);

// ===== tb/tb_rgba_pixel_filter_3x3_unit.sv =====
// Testbench of the streaming RGBA 3x3 pixel filter: drives frames, flushes and
// register writes, predicts every filtered word and compares it at the output.
// Depends on rpf3_pkg and rgba_pixel_filter_3x3_unit.
`timescale 1ns / 1ps

module tb_rgba_pixel_filter_3x3_unit;
  import rpf3_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       fend;
  } pixel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_red_i = '0;
  logic [7:0]  in_green_i = '0;
  logic [7:0]  in_blue_i = '0;
  logic [7:0]  in_alpha_i = '0;
  logic        is_flush_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_alpha_o;
  logic        frame_end_o;

  rgba_pixel_filter_3x3_unit dut (.*);

  // The clock runs with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block: registers, line buffers, window and position.
  logic [2:0]  mdl_mode;
  logic [10:0] mdl_width;
  logic [12:0] mdl_height;
  logic [31:0] line_prev [MaxWidthDef];
  logic [31:0] line_prev2 [MaxWidthDef];
  logic [31:0] win_regs [9];
  int unsigned col_pos;
  int unsigned row_pos;

  pixel_out_t  pending_pixels [$];
  int          mismatch_count = 0;
  // When quiet is set, neither side idles, giving a long stretch at full rate.
  bit          quiet = 1'b0;

  function automatic int unsigned active_width();
    int unsigned w;
    w = (mdl_width == 0) ? 1 : mdl_width;
    if (w > MaxWidthDef) w = MaxWidthDef;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (mdl_height == 0) ? 1 : mdl_height;
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Advances the shadow state by one word and queues the filtered pixel it
  // releases, if any.
  function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic flush);
    int unsigned w, h, x, y, cx, cy, lc, cc, rc, tr, br, sr, gray;
    logic [31:0] px, top, mid, ctr;
    logic [31:0] win [9];
    int unsigned cr, cg, cb;
    int sum;
    bit emit, last;
    pixel_out_t o;
    w = active_width();
    h = active_height();
    x = col_pos;
    y = row_pos;
    lc = 0; cc = 1; rc = 2; tr = 0; br = 2;
    if (x >= w) begin
      x = 0;
      y = 0;
    end
    px = flush ? 32'd0 : {a, b, g, r};
    top = line_prev2[x];
    mid = line_prev[x];
    line_prev2[x] = mid;
    line_prev[x] = px;
    for (int i = 0; i < 3; i++) begin
      win_regs[i*3] = win_regs[i*3+1];
      win_regs[i*3+1] = win_regs[i*3+2];
    end
    win_regs[2] = top;
    win_regs[5] = mid;
    win_regs[8] = px;
    emit = (y >= 2) || (y == 1 && x >= 1);
    if (x == 0) begin
      cx = w - 1;
      cy = y - 2;
    end else begin
      cx = x - 1;
      cy = y - 1;
    end
    last = emit && cx == w - 1 && cy == h - 1;
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end else if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    if (!emit) return;
    if (cx == 0) lc = cc;
    if (cx == w - 1) rc = cc;
    if (cy == 0) tr = 1;
    if (cy == h - 1) br = 1;
    for (int i = 0; i < 3; i++) begin
      sr = (i == 0) ? tr : ((i == 1) ? 1 : br);
      win[i*3] = win_regs[sr*3+lc];
      win[i*3+1] = win_regs[sr*3+cc];
      win[i*3+2] = win_regs[sr*3+rc];
    end
    ctr = win[4];
    cr = 32'(ctr[7:0]);
    cg = 32'(ctr[15:8]);
    cb = 32'(ctr[23:16]);
    gray = (cr * 11 + cg * 16 + cb * 5) / 32;
    o.alpha = ctr[31:24];
    o.fend = last;
    case (mdl_mode)
      ModeGray: begin
        o.red = 8'(gray); o.green = 8'(gray); o.blue = 8'(gray);
      end
      ModeInvert: begin
        o.red = 8'(255 - cr); o.green = 8'(255 - cg); o.blue = 8'(255 - cb);
      end
      ModeBinary: begin
        o.red = (gray > 128) ? 8'd255 : 8'd0;
        o.green = o.red;
        o.blue = o.red;
      end
      ModeWarm: begin
        o.red = clamp8(cr * 23 / 20);
        o.green = clamp8(cg * 21 / 20);
        o.blue = clamp8(cb * 18 / 20);
      end
      ModeCool: begin
        o.red = clamp8(cr * 18 / 20);
        o.green = 8'(cg);
        o.blue = clamp8(cb * 23 / 20);
      end
      ModeEdge, ModeSharpen: begin
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int i = 0; i < 9; i++) begin
            sum += ((mdl_mode == ModeEdge) ? int'(KEdge[i]) : int'(KSharp[i]))
                   * int'(win[i][8*c +: 8]);
          end
          if (c == 0) o.red = clamp8(sum);
          else if (c == 1) o.green = clamp8(sum);
          else o.blue = clamp8(sum);
        end
      end
      default: begin
        o.red = 8'(cr); o.green = 8'(cg); o.blue = 8'(cb);
      end
    endcase
    pending_pixels.push_back(o);
  endfunction

  // Sends one word and feeds it to the predictor on the edge it is accepted.
  // Valid stays high afterwards so that words can follow back to back; the
  // next idle cycle or the drain takes it low.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic flush);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    in_alpha_i <= a;
    is_flush_i <= flush;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel(r, g, b, a, flush);
  endtask

  // Waits for every expected word, then for the pipeline's own latency.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle and mirrors it in the shadow copy.
  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMode: mdl_mode = value[2:0];
      RegWidth: begin
        mdl_width = value[10:0];
        col_pos = 0;
        row_pos = 0;
      end
      RegHeight: begin
        mdl_height = value;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
  endtask

  // One frame: pixels of the given style then the width+1 flush words.
  // Style 0 is random, 1 is all-ones, 2 is all-zero, 3 is a checkerboard.
  task automatic send_frame(int unsigned w, int unsigned h, int style);
    logic [7:0] v;
    for (int unsigned i = 0; i < w * h; i++) begin
      case (style)
        1: send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        2: send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        3: begin
          v = (((i % w) + (i / w)) % 2) ? 8'hFF : 8'h00;
          send_pixel(v, ~v, v, 8'($urandom_range(255)), 1'b0);
        end
        default: send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             $urandom_range(99) < 3);
      endcase
    end
    // The drain carries random channel bits, which the block must ignore.
    for (int unsigned i = 0; i <= w; i++) begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(RegWidth, 13'(w));
    write_reg(RegHeight, 13'(h));
  endtask

  // Directed part: extreme pixel values, a checkerboard, every mode.
  task automatic test_every_mode();
    set_size(3, 3);
    for (int m = 0; m < 8; m++) begin
      write_reg(RegMode, 13'(m));
      send_frame(3, 3, (m % 2 == 0) ? 1 : 3);
    end
    write_reg(RegMode, 13'(ModeSharpen));
    send_frame(3, 3, 2);
  endtask

  // Narrow and flat frames, including zero sizes that act as one.
  task automatic test_odd_sizes();
    write_reg(RegMode, 13'(ModeEdge));
    set_size(0, 0);
    send_frame(1, 1, 0);
    set_size(1, 4);
    send_frame(1, 4, 0);
    set_size(5, 1);
    send_frame(5, 1, 0);
    write_reg(RegMode, 13'(ModeSharpen));
    set_size(2, 2);
    send_frame(2, 2, 0);
  endtask

  // A width over the maximum acts as the maximum. One full row and the start
  // of the next show where the row wraps; the next size write restarts it.
  task automatic test_widest_frame();
    write_reg(RegMode, 13'(ModeSharpen));
    set_size(2047, 2);
    for (int unsigned i = 0; i < MaxWidthDef + 40; i++) begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Random small frames in random modes, a long quiet stretch, then a pass frame.
  task automatic test_random_frames();
    int unsigned w, h;
    for (int n = 0; n < 26; n++) begin
      write_reg(RegMode, 13'($urandom_range(7)));
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      set_size(w, h);
      quiet = (n >= 16);
      send_frame(w, h, 0);
    end
    quiet = 1'b0;
    write_reg(RegMode, 13'(ModePass));
    write_reg(2'd3, 13'h1FFF);
    send_frame(w, h, 0);
  endtask

  // The receiver stalls at random, except during the quiet stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 11);
  end

  // Compares every accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_out_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_red_o, out_green_o, out_blue_o, out_alpha_o, frame_end_o};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
    end
  end

  initial begin
    mdl_mode = ModePass;
    mdl_width = WidthRst;
    mdl_height = HeightRst;
    col_pos = 0;
    row_pos = 0;
    foreach (win_regs[i]) win_regs[i] = '0;
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_every_mode();
    test_odd_sizes();
    test_widest_frame();
    test_random_frames();
    drain_results();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Safety limit far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rpf3_pkg.sv
sv/rpf3_front.sv
sv/rpf3_queue.sv
sv/rpf3_back.sv
sv/rgba_pixel_filter_3x3_unit.sv
sv/rpf3_checker.sv
tb/tb_rgba_pixel_filter_3x3_unit.sv
